// ----- rtl/core/lprcp_pkg.sv -----
// ----------------------------------------------------------------------------
// lprcp_pkg
// Shared types, codes and command tables for the label printer raster
// command parser.
// ----------------------------------------------------------------------------
package lprcp_pkg;

  // bytes of invalidate preamble skipped at the start of a buffer
  localparam logic [7:0] PREAMBLE_LENGTH = 8'd200;

  // top-level command bytes
  localparam logic [7:0] CH_MODE      = 8'h4d;  // 'M'
  localparam logic [7:0] CH_RASTER    = 8'h47;  // 'G'
  localparam logic [7:0] CH_EMPTY     = 8'h5a;  // 'Z'
  localparam logic [7:0] CH_PAGE_END  = 8'h1a;
  localparam logic [7:0] CH_ESC       = 8'h1b;
  localparam logic [7:0] CH_INIT      = 8'h40;  // '@'
  localparam logic [7:0] CH_INFO      = 8'h69;  // 'i'
  localparam logic [7:0] CH_STATUS    = 8'h53;  // 'S'
  localparam logic [7:0] MODE_TIFF    = 8'h02;
  localparam logic [7:0] PB_NOOP      = 8'h80;

  // ESC i letters that take arguments
  localparam logic [7:0] CH_LET_A_LO  = 8'h61;  // 'a'
  localparam logic [7:0] CH_LET_Z_LO  = 8'h7a;  // 'z'
  localparam logic [7:0] CH_LET_M_UP  = 8'h4d;  // 'M'
  localparam logic [7:0] CH_LET_K_UP  = 8'h4b;  // 'K'
  localparam logic [7:0] CH_LET_D_LO  = 8'h64;  // 'd'
  localparam logic [7:0] CH_LET_A_UP  = 8'h41;  // 'A'
  localparam logic [7:0] CH_LET_U_UP  = 8'h55;  // 'U'
  localparam logic [7:0] CH_LET_K_LO  = 8'h6b;  // 'k'

  typedef enum logic [2:0] {
    EV_RUN      = 3'd0,
    EV_EMPTY    = 3'd1,
    EV_MODE     = 3'd2,
    EV_INIT     = 3'd3,
    EV_ARG      = 3'd4,
    EV_STATUS   = 3'd5,
    EV_PAGE_END = 3'd6,
    EV_ERROR    = 3'd7
  } event_kind_t;

  typedef enum logic [8:0] {
    PH_PRE  = 9'b000000001,
    PH_TOP  = 9'b000000010,
    PH_MODE = 9'b000000100,
    PH_GLO  = 9'b000001000,
    PH_GHI  = 9'b000010000,
    PH_PAY  = 9'b000100000,
    PH_ESC  = 9'b001000000,
    PH_LET  = 9'b010000000,
    PH_ARG  = 9'b100000000
  } phase_t;

  typedef enum logic [2:0] {
    RUN_HDR = 3'b001,
    RUN_LIT = 3'b010,
    RUN_REP = 3'b100
  } run_phase_t;

  typedef struct packed {
    event_kind_t kind;
    logic [7:0]  value;
    logic [7:0]  repeat_cnt;
    logic        line_done;
    logic [7:0]  letter;
    logic [3:0]  position;
  } result_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] count;
  } arg_info_t;

  function automatic arg_info_t arg_count(input logic [7:0] c);
    arg_info_t info;
    info.ok    = 1'b1;
    info.count = 4'd0;
    case (c)
      CH_LET_A_LO, CH_LET_M_UP, CH_LET_K_UP, CH_LET_A_UP: info.count = 4'd1;
      CH_LET_Z_LO: info.count = 4'd10;
      CH_LET_D_LO: info.count = 4'd2;
      CH_LET_U_UP: info.count = 4'd15;
      CH_LET_K_LO: info.count = 4'd3;
      CH_STATUS:   info.count = 4'd0;
      default:     info.ok    = 1'b0;
    endcase
    return info;
  endfunction

endpackage

// ----- rtl/core/label_printer_raster_command_parser.sv -----
// ----------------------------------------------------------------------------
// label_printer_raster_command_parser
// Parses a printer command stream one byte per request, decodes PackBits
// raster payloads and emits runs, command arguments and events.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake           payload
//  in_      input      in_valid/in_stall   stream_byte, final_byte
//  out_     output     out_valid/out_stall event_kind .. argument_position
//  cfg_     input      cfg_wr_en           skip_preamble
//
// One request per cycle; a request's result, if any, appears in the output
// register on the next cycle. The parser state updates in the same cycle.
// Input stalls only while the output register holds a result and out_stall
// is high. Synchronous active-low reset clears the parser and sets
// skip_preamble. After page end or an error every request is consumed with
// no result until reset.
module label_printer_raster_command_parser (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic                      cfg_wr_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [7:0]                in_stream_byte,
  input  logic                      in_final_byte,
  output logic                      out_valid,
  input  logic                      out_stall,
  output lprcp_pkg::event_kind_t    out_event_kind,
  output logic [7:0]                out_value_byte,
  output logic [7:0]                out_repeat_count,
  output logic                      out_line_done,
  output logic [7:0]                out_command_letter,
  output logic [3:0]                out_argument_position
);
  import lprcp_pkg::*;

  logic        skip_preamble_r;
  phase_t      phase_r, phase_nxt;
  logic [7:0]  preamble_seen_r, preamble_seen_nxt;
  logic        tiff_r, tiff_nxt;
  logic [7:0]  letter_r, letter_nxt;
  logic [3:0]  args_left_r, args_left_nxt;
  logic [3:0]  arg_cnt_r, arg_cnt_nxt;
  logic [7:0]  len_lo_r, len_lo_nxt;
  logic [15:0] line_left_r, line_left_nxt;
  run_phase_t  run_phase_r, run_phase_nxt;
  logic [7:0]  run_left_r, run_left_nxt;
  logic        stopped_r, stopped_nxt;

  logic        out_valid_r, out_valid_nxt;
  result_t     res_r, res;
  logic        res_valid;
  logic        in_accept;
  logic        res_load;

  assign in_stall  = out_valid_r & out_stall;
  assign in_accept = in_valid & ~in_stall;
  assign res_load  = in_accept & res_valid;

  always_comb begin
    logic        skip_byte;
    logic        early;
    logic        err;
    logic        clear_buf;
    logic [7:0]  b;
    logic        fin;
    logic [15:0] left;
    logic        done;
    phase_t      ph;
    arg_info_t   info;

    phase_nxt         = phase_r;
    preamble_seen_nxt = preamble_seen_r;
    tiff_nxt          = tiff_r;
    letter_nxt        = letter_r;
    args_left_nxt     = args_left_r;
    arg_cnt_nxt       = arg_cnt_r;
    len_lo_nxt        = len_lo_r;
    line_left_nxt     = line_left_r;
    run_phase_nxt     = run_phase_r;
    run_left_nxt      = run_left_r;
    stopped_nxt       = stopped_r;

    res       = '0;
    res_valid = 1'b0;
    skip_byte = 1'b0;
    early     = 1'b0;
    err       = 1'b0;
    clear_buf = 1'b0;
    b         = in_stream_byte;
    fin       = in_final_byte;
    left      = line_left_r - 16'd1;
    done      = (left == 16'd0);
    ph        = phase_r;
    info      = arg_count(b);

    if (!stopped_r) begin
      if (phase_r == PH_PRE) begin
        if (skip_preamble_r && (preamble_seen_r < PREAMBLE_LENGTH)) begin
          preamble_seen_nxt = preamble_seen_r + 8'd1;
          skip_byte = 1'b1;
          clear_buf = fin;
        end else begin
          ph = PH_TOP;
        end
      end

      if (!skip_byte) begin
        phase_nxt = ph;
        case (ph)
          PH_TOP: begin
            if (b == CH_MODE) begin
              phase_nxt = PH_MODE;
            end else if (b == CH_RASTER) begin
              phase_nxt = PH_GLO;
            end else if (b == CH_EMPTY) begin
              res_valid = 1'b1;
              res.kind  = EV_EMPTY;
            end else if (b == CH_PAGE_END) begin
              stopped_nxt = 1'b1;
              early       = 1'b1;
              res_valid   = 1'b1;
              res.kind    = EV_PAGE_END;
            end else if (b == CH_ESC) begin
              phase_nxt = PH_ESC;
            end else begin
              err = 1'b1;
            end
          end
          PH_MODE: begin
            tiff_nxt  = (b == MODE_TIFF);
            res_valid = 1'b1;
            res.kind  = EV_MODE;
            res.value = b;
            phase_nxt = PH_TOP;
          end
          PH_GLO: begin
            len_lo_nxt = b;
            phase_nxt  = PH_GHI;
          end
          PH_GHI: begin
            line_left_nxt = {b, len_lo_r};
            if ({b, len_lo_r} == 16'd0) begin
              res_valid     = 1'b1;
              res.kind      = EV_RUN;
              res.line_done = 1'b1;
              phase_nxt     = PH_TOP;
            end else begin
              phase_nxt     = PH_PAY;
              run_phase_nxt = RUN_HDR;
              run_left_nxt  = 8'd0;
            end
          end
          PH_PAY: begin
            line_left_nxt = left;
            res.kind      = EV_RUN;
            res.line_done = done;
            if (!tiff_r) begin
              res_valid      = 1'b1;
              res.value      = b;
              res.repeat_cnt = 8'd1;
            end else if (run_phase_r == RUN_HDR) begin
              if (b == PB_NOOP) begin
                // a no-op header that closes the line still reports the end
                res_valid = done;
              end else if (b > PB_NOOP) begin
                if (done) begin
                  err = 1'b1;
                end else begin
                  run_left_nxt  = 8'(9'd257 - {1'b0, b});
                  run_phase_nxt = RUN_REP;
                end
              end else begin
                if (({8'd0, b} + 16'd1) > left) begin
                  err = 1'b1;
                end else begin
                  run_left_nxt  = b + 8'd1;
                  run_phase_nxt = RUN_LIT;
                end
              end
            end else if (run_phase_r == RUN_LIT) begin
              res_valid      = 1'b1;
              res.value      = b;
              res.repeat_cnt = 8'd1;
              run_left_nxt   = run_left_r - 8'd1;
              if (run_left_r == 8'd1) begin
                run_phase_nxt = RUN_HDR;
              end
            end else begin
              res_valid      = 1'b1;
              res.value      = b;
              res.repeat_cnt = run_left_r;
              run_left_nxt   = 8'd0;
              run_phase_nxt  = RUN_HDR;
            end
            if (done && !err) begin
              phase_nxt     = PH_TOP;
              run_phase_nxt = RUN_HDR;
              run_left_nxt  = 8'd0;
            end
          end
          PH_ESC: begin
            if (b == CH_INIT) begin
              res_valid = 1'b1;
              res.kind  = EV_INIT;
              phase_nxt = PH_TOP;
            end else if (b == CH_INFO) begin
              phase_nxt = PH_LET;
            end else begin
              err = 1'b1;
            end
          end
          PH_LET: begin
            if (!info.ok) begin
              err = 1'b1;
            end else if (info.count == 4'd0) begin
              res_valid  = 1'b1;
              res.kind   = EV_STATUS;
              res.letter = CH_STATUS;
              phase_nxt  = PH_TOP;
            end else begin
              letter_nxt    = b;
              args_left_nxt = info.count;
              arg_cnt_nxt   = 4'd0;
              phase_nxt     = PH_ARG;
            end
          end
          PH_ARG: begin
            res_valid     = 1'b1;
            res.kind      = EV_ARG;
            res.value     = b;
            res.letter    = letter_r;
            res.position  = arg_cnt_r;
            arg_cnt_nxt   = arg_cnt_r + 4'd1;
            args_left_nxt = args_left_r - 4'd1;
            if (args_left_r == 4'd1) begin
              phase_nxt = PH_TOP;
            end
          end
          default: begin
            phase_nxt = PH_TOP;
            err       = 1'b1;
          end
        endcase

        // a buffer may only end between commands
        if (!early && !err && fin) begin
          if (phase_nxt != PH_TOP) begin
            err = 1'b1;
          end else begin
            clear_buf = 1'b1;
          end
        end
      end
    end

    if (err) begin
      stopped_nxt = 1'b1;
      res_valid   = 1'b1;
      res         = '0;
      res.kind    = EV_ERROR;
      res.value   = b;
    end

    if (clear_buf) begin
      phase_nxt         = PH_PRE;
      preamble_seen_nxt = 8'd0;
      tiff_nxt          = 1'b0;
      letter_nxt        = 8'd0;
      args_left_nxt     = 4'd0;
      arg_cnt_nxt       = 4'd0;
      len_lo_nxt        = 8'd0;
      line_left_nxt     = 16'd0;
      run_phase_nxt     = RUN_HDR;
      run_left_nxt      = 8'd0;
    end
  end

  always_comb begin
    if (res_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skip_preamble_r <= 1'b1;
      phase_r         <= PH_PRE;
      preamble_seen_r <= 8'd0;
      tiff_r          <= 1'b0;
      letter_r        <= 8'd0;
      args_left_r     <= 4'd0;
      arg_cnt_r       <= 4'd0;
      len_lo_r        <= 8'd0;
      line_left_r     <= 16'd0;
      run_phase_r     <= RUN_HDR;
      run_left_r      <= 8'd0;
      stopped_r       <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        skip_preamble_r <= cfg_wr_data;
      end
      if (in_accept) begin
        phase_r         <= phase_nxt;
        preamble_seen_r <= preamble_seen_nxt;
        tiff_r          <= tiff_nxt;
        letter_r        <= letter_nxt;
        args_left_r     <= args_left_nxt;
        arg_cnt_r       <= arg_cnt_nxt;
        len_lo_r        <= len_lo_nxt;
        line_left_r     <= line_left_nxt;
        run_phase_r     <= run_phase_nxt;
        run_left_r      <= run_left_nxt;
        stopped_r       <= stopped_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_r <= res;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_event_kind        = res_r.kind;
  assign out_value_byte        = res_r.value;
  assign out_repeat_count      = res_r.repeat_cnt;
  assign out_line_done         = res_r.line_done;
  assign out_command_letter    = res_r.letter;
  assign out_argument_position = res_r.position;

  // once halted, only reset restarts the parser
  a_stopped_holds: assert property (@(posedge clk) disable iff (!rst_n)
    stopped_r && rst_n |=> stopped_r)
    else $error("halted parser restarted without reset");

  a_no_result_when_stopped: assert property (@(posedge clk) disable iff (!rst_n)
    stopped_r |-> !res_load)
    else $error("result produced while halted");

  a_payload_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_PAY) && !stopped_r |-> (line_left_r != 16'd0))
    else $error("payload phase with no bytes left in line");

  a_run_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    (run_phase_r != RUN_HDR) && !stopped_r |-> (run_left_r != 8'd0))
    else $error("packbits run active with zero count");

  a_repeat_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (res_r.kind == EV_RUN) |-> (res_r.repeat_cnt <= 8'd128))
    else $error("raster run repeat count out of range");

endmodule

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Byte-stream check of the label printer raster command parser. Requests are
// mostly well-formed commands (mode select, raster lines in both encodings,
// empty lines, initialize, ESC i commands) with random content. Preamble
// skipping and buffer ends are exercised, and the run ends with one halting
// byte followed by ignored bytes. Every accepted result is compared field by
// field against an in-bench parser model or a pinned row's hand-written result.
// ----------------------------------------------------------------------------
module tb;
  import lprcp_pkg::*;

  localparam int CYCLE_LIMIT = 500000;

  typedef struct packed {
    logic [7:0] b;
    logic       fin;
    logic       pin;   // row carries a hand-written result
    result_t    res;
  } req_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic        cfg_wr_data = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic        out_stall = 1'b0;
  event_kind_t out_event_kind;
  logic [7:0]  out_value_byte;
  logic [7:0]  out_repeat_count;
  logic        out_line_done;
  logic [7:0]  out_command_letter;
  logic [3:0]  out_argument_position;
  req_t        cur_req = '0;

  label_printer_raster_command_parser dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_wr_en             (cfg_wr_en),
    .cfg_wr_data           (cfg_wr_data),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_stream_byte        (cur_req.b),
    .in_final_byte         (cur_req.fin),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_event_kind        (out_event_kind),
    .out_value_byte        (out_value_byte),
    .out_repeat_count      (out_repeat_count),
    .out_line_done         (out_line_done),
    .out_command_letter    (out_command_letter),
    .out_argument_position (out_argument_position)
  );

  // directed rows: {byte, final, pinned, kind, value, repeat, done, letter, pos}
  req_t dir_rows [27] = '{
    {CH_EMPTY,    1'b0, 1'b1, EV_EMPTY,  8'h00, 8'd0,   1'b0, 8'h00, 4'd0},
    {CH_MODE,     1'b0, 1'b0, 32'd0},
    {MODE_TIFF,   1'b0, 1'b1, EV_MODE,   8'h02, 8'd0,   1'b0, 8'h00, 4'd0},
    {CH_RASTER,   1'b0, 1'b0, 32'd0},
    {8'h01,       1'b0, 1'b0, 32'd0},
    {8'h00,       1'b0, 1'b0, 32'd0},
    {PB_NOOP,     1'b0, 1'b1, EV_RUN,    8'h00, 8'd0,   1'b1, 8'h00, 4'd0},
    {CH_RASTER,   1'b0, 1'b0, 32'd0},
    {8'h02,       1'b0, 1'b0, 32'd0},
    {8'h00,       1'b0, 1'b0, 32'd0},
    {8'h81,       1'b0, 1'b0, 32'd0},
    {8'hff,       1'b0, 1'b1, EV_RUN,    8'hff, 8'd128, 1'b1, 8'h00, 4'd0},
    {CH_RASTER,   1'b0, 1'b0, 32'd0},
    {8'h00,       1'b0, 1'b0, 32'd0},
    {8'h00,       1'b0, 1'b1, EV_RUN,    8'h00, 8'd0,   1'b1, 8'h00, 4'd0},
    {CH_ESC,      1'b0, 1'b0, 32'd0},
    {CH_INIT,     1'b0, 1'b1, EV_INIT,   8'h00, 8'd0,   1'b0, 8'h00, 4'd0},
    {CH_ESC,      1'b0, 1'b0, 32'd0},
    {CH_INFO,     1'b0, 1'b0, 32'd0},
    {CH_STATUS,   1'b0, 1'b1, EV_STATUS, 8'h00, 8'd0,   1'b0, CH_STATUS, 4'd0},
    {CH_ESC,      1'b0, 1'b0, 32'd0},
    {CH_INFO,     1'b0, 1'b0, 32'd0},
    {CH_LET_D_LO, 1'b0, 1'b0, 32'd0},
    {8'hff,       1'b0, 1'b1, EV_ARG,    8'hff, 8'd0,   1'b0, CH_LET_D_LO, 4'd0},
    {8'h00,       1'b0, 1'b1, EV_ARG,    8'h00, 8'd0,   1'b0, CH_LET_D_LO, 4'd1},
    {CH_MODE,     1'b0, 1'b0, 32'd0},
    {8'h00,       1'b1, 1'b1, EV_MODE,   8'h00, 8'd0,   1'b0, 8'h00, 4'd0}
  };

  logic [7:0] known_letters [9] = '{CH_LET_A_LO, CH_LET_Z_LO, CH_LET_M_UP, CH_LET_K_UP,
                                    CH_LET_D_LO, CH_LET_A_UP, CH_LET_U_UP, CH_LET_K_LO,
                                    CH_STATUS};

  req_t    req_q [$];
  result_t expected_q [$];
  result_t pred_res;
  int      errors = 0;
  int      cycle_count = 0;
  int      items_queued = 0;
  int      send_pct = 0;
  int      recv_pct = 0;
  int      fin_odds = 50;
  int      pressure_count = 0;
  int      pressure_done = 0;
  int      hold_left = 0;
  bit      gen_skip = 1'b1;
  bit      gen_tiff = 1'b0;

  // parser model state
  bit         cfg_skip;
  bit         halted;
  phase_t     ph;
  logic [7:0] pre_seen;
  bit         tiff_on;
  logic [7:0] pend_letter;
  logic [3:0] args_left;
  logic [3:0] arg_idx;
  logic [7:0] len_lo;
  logic [15:0] line_left;
  run_phase_t rph;
  logic [7:0] run_cnt;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  function automatic logic [7:0] rnd_byte();
    return 8'($urandom);
  endfunction

  // -1 for a letter that the parser rejects
  function automatic int args_of_letter(input logic [7:0] c);
    case (c)
      CH_LET_A_LO, CH_LET_M_UP, CH_LET_K_UP, CH_LET_A_UP: return 1;
      CH_LET_Z_LO: return 10;
      CH_LET_D_LO: return 2;
      CH_LET_U_UP: return 15;
      CH_LET_K_LO: return 3;
      CH_STATUS:   return 0;
      default:     return -1;
    endcase
  endfunction

  function automatic result_t mk(input event_kind_t k, input logic [7:0] v,
                                 input logic [7:0] rep, input logic d,
                                 input logic [7:0] ltr, input logic [3:0] pos);
    result_t r;
    r.kind       = k;
    r.value      = v;
    r.repeat_cnt = rep;
    r.line_done  = d;
    r.letter     = ltr;
    r.position   = pos;
    return r;
  endfunction

  function automatic void start_buffer();
    ph          = PH_PRE;
    pre_seen    = 8'd0;
    tiff_on     = 1'b0;
    pend_letter = 8'd0;
    args_left   = 4'd0;
    arg_idx     = 4'd0;
    len_lo      = 8'd0;
    line_left   = 16'd0;
    rph         = RUN_HDR;
    run_cnt     = 8'd0;
  endfunction

  function automatic bit halt_err(input logic [7:0] b, output result_t r);
    halted = 1'b1;
    r = mk(EV_ERROR, b, 8'd0, 1'b0, 8'd0, 4'd0);
    return 1'b1;
  endfunction

  // one raster payload byte, raw or packbits
  function automatic bit line_byte(input logic [7:0] b, output result_t r);
    bit done;
    bit got;
    r = '0;
    got = 1'b0;
    line_left = line_left - 16'd1;
    done = (line_left == 16'd0);
    if (!tiff_on) begin
      r = mk(EV_RUN, b, 8'd1, done, 8'd0, 4'd0);
      got = 1'b1;
    end else if (rph == RUN_HDR) begin
      if (b == PB_NOOP) begin
        if (done) begin
          r = mk(EV_RUN, 8'd0, 8'd0, 1'b1, 8'd0, 4'd0);
          got = 1'b1;
        end
      end else if (b > PB_NOOP) begin
        if (line_left < 16'd1) return halt_err(b, r);
        run_cnt = 8'(9'd257 - {1'b0, b});
        rph = RUN_REP;
      end else begin
        if ({8'd0, b} + 16'd1 > line_left) return halt_err(b, r);
        run_cnt = b + 8'd1;
        rph = RUN_LIT;
      end
    end else if (rph == RUN_LIT) begin
      r = mk(EV_RUN, b, 8'd1, done, 8'd0, 4'd0);
      got = 1'b1;
      run_cnt = run_cnt - 8'd1;
      if (run_cnt == 8'd0) rph = RUN_HDR;
    end else begin
      r = mk(EV_RUN, b, run_cnt, done, 8'd0, 4'd0);
      got = 1'b1;
      run_cnt = 8'd0;
      rph = RUN_HDR;
    end
    if (done) begin
      ph = PH_TOP;
      rph = RUN_HDR;
      run_cnt = 8'd0;
    end
    return got;
  endfunction

  function automatic bit parse_byte(input logic [7:0] b, input logic fin,
                                    output result_t r);
    bit got;
    int n;
    r = '0;
    got = 1'b0;
    if (halted) return 1'b0;
    if (ph == PH_PRE) begin
      if (cfg_skip && pre_seen < PREAMBLE_LENGTH) begin
        pre_seen = pre_seen + 8'd1;
        if (fin) start_buffer();
        return 1'b0;
      end
      ph = PH_TOP;
    end
    case (ph)
      PH_TOP: begin
        if (b == CH_MODE) ph = PH_MODE;
        else if (b == CH_RASTER) ph = PH_GLO;
        else if (b == CH_EMPTY) begin
          r = mk(EV_EMPTY, 8'd0, 8'd0, 1'b0, 8'd0, 4'd0);
          got = 1'b1;
        end else if (b == CH_PAGE_END) begin
          halted = 1'b1;
          r = mk(EV_PAGE_END, 8'd0, 8'd0, 1'b0, 8'd0, 4'd0);
          return 1'b1;
        end else if (b == CH_ESC) ph = PH_ESC;
        else return halt_err(b, r);
      end
      PH_MODE: begin
        tiff_on = (b == MODE_TIFF);
        r = mk(EV_MODE, b, 8'd0, 1'b0, 8'd0, 4'd0);
        got = 1'b1;
        ph = PH_TOP;
      end
      PH_GLO: begin
        len_lo = b;
        ph = PH_GHI;
      end
      PH_GHI: begin
        line_left = {b, len_lo};
        if (line_left == 16'd0) begin
          r = mk(EV_RUN, 8'd0, 8'd0, 1'b1, 8'd0, 4'd0);
          got = 1'b1;
          ph = PH_TOP;
        end else begin
          ph = PH_PAY;
          rph = RUN_HDR;
          run_cnt = 8'd0;
        end
      end
      PH_PAY: begin
        got = line_byte(b, r);
        if (halted) return got;
      end
      PH_ESC: begin
        if (b == CH_INIT) begin
          r = mk(EV_INIT, 8'd0, 8'd0, 1'b0, 8'd0, 4'd0);
          got = 1'b1;
          ph = PH_TOP;
        end else if (b == CH_INFO) ph = PH_LET;
        else return halt_err(b, r);
      end
      PH_LET: begin
        n = args_of_letter(b);
        if (n < 0) return halt_err(b, r);
        if (n == 0) begin
          r = mk(EV_STATUS, 8'd0, 8'd0, 1'b0, CH_STATUS, 4'd0);
          got = 1'b1;
          ph = PH_TOP;
        end else begin
          pend_letter = b;
          args_left = 4'(n);
          arg_idx = 4'd0;
          ph = PH_ARG;
        end
      end
      PH_ARG: begin
        r = mk(EV_ARG, b, 8'd0, 1'b0, pend_letter, arg_idx);
        got = 1'b1;
        arg_idx = arg_idx + 4'd1;
        args_left = args_left - 4'd1;
        if (args_left == 4'd0) ph = PH_TOP;
      end
      default: begin
        ph = PH_TOP;
        return halt_err(b, r);
      end
    endcase
    // a buffer may only end on a command boundary
    if (fin) begin
      if (ph != PH_TOP) return halt_err(b, r);
      start_buffer();
    end
    return got;
  endfunction

  task automatic flag_mismatch(input string msg);
    errors++;
    if (errors <= 40) $display("tb: mismatch: %s", msg);
  endtask

  task automatic check_result();
    result_t e;
    if (expected_q.size() == 0) begin
      flag_mismatch($sformatf("unexpected result kind %0d value %0h",
                              out_event_kind, out_value_byte));
    end else begin
      e = expected_q.pop_front();
      if (out_event_kind !== e.kind)
        flag_mismatch($sformatf("event_kind %0d, expected %0d", out_event_kind, e.kind));
      if (out_value_byte !== e.value)
        flag_mismatch($sformatf("value_byte %0h, expected %0h", out_value_byte, e.value));
      if (out_repeat_count !== e.repeat_cnt)
        flag_mismatch($sformatf("repeat_count %0d, expected %0d",
                                out_repeat_count, e.repeat_cnt));
      if (out_line_done !== e.line_done)
        flag_mismatch($sformatf("line_done %0b, expected %0b", out_line_done, e.line_done));
      if (out_command_letter !== e.letter)
        flag_mismatch($sformatf("command_letter %0h, expected %0h",
                                out_command_letter, e.letter));
      if (out_argument_position !== e.position)
        flag_mismatch($sformatf("argument_position %0d, expected %0d",
                                out_argument_position, e.position));
    end
  endtask

  // request side
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && in_stall)) begin
      if (req_q.size() > 0 && $urandom_range(0, 99) >= send_pct) begin
        cur_req <= req_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result side, with a long hold-off on request
  always @(posedge clk) begin
    if (pressure_done != pressure_count) begin
      pressure_done = pressure_count;
      hold_left = 600;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      if (cur_req.pin) begin
        void'(parse_byte(cur_req.b, cur_req.fin, pred_res));
        expected_q.push_back(cur_req.res);
      end else if (parse_byte(cur_req.b, cur_req.fin, pred_res)) begin
        expected_q.push_back(pred_res);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_result();
  end

  task automatic push_req(input logic [7:0] b, input logic fin, input bit counted);
    req_q.push_back({b, fin, 1'b0, 32'd0});
    if (counted) items_queued++;
  endtask

  // a final byte inside the preamble restarts it
  task automatic feed_preamble(input int n, input bit may_end);
    int i;
    bit fin;
    i = 0;
    while (i < n) begin
      fin = may_end && ($urandom_range(0, 149) == 0);
      push_req(rnd_byte(), fin, 1'b1);
      i = fin ? 0 : i + 1;
    end
  endtask

  task automatic gen_command(input bit force_fin);
    logic [7:0] cmd [$];
    logic [7:0] mode;
    logic [7:0] letter;
    int pick;
    int len;
    int rem;
    int n;
    bit fin;
    pick = $urandom_range(0, 99);
    mode = 8'd0;
    if (pick < 40) begin
      if ($urandom_range(0, 79) == 0) len = $urandom_range(256, 270);
      else if ($urandom_range(0, 11) == 0) len = 0;
      else len = $urandom_range(1, 40);
      cmd.push_back(CH_RASTER);
      cmd.push_back(len[7:0]);
      cmd.push_back(len[15:8]);
      rem = len;
      while (rem > 0) begin
        if (!gen_tiff) begin
          cmd.push_back(rnd_byte());
          rem--;
        end else if (rem == 1 || $urandom_range(0, 9) == 0) begin
          cmd.push_back(PB_NOOP);
          rem--;
        end else if ($urandom_range(0, 1) == 1) begin
          cmd.push_back(8'($urandom_range(8'h81, 8'hff)));
          cmd.push_back(rnd_byte());
          rem -= 2;
        end else begin
          n = $urandom_range(0, (rem - 2 > 127) ? 127 : rem - 2);
          cmd.push_back(n[7:0]);
          repeat (n + 1) cmd.push_back(rnd_byte());
          rem -= n + 2;
        end
      end
    end else if (pick < 52) begin
      mode = ($urandom_range(0, 1) == 1) ? MODE_TIFF : rnd_byte();
      cmd.push_back(CH_MODE);
      cmd.push_back(mode);
    end else if (pick < 62) begin
      cmd.push_back(CH_EMPTY);
    end else if (pick < 67) begin
      cmd.push_back(CH_ESC);
      cmd.push_back(CH_INIT);
    end else begin
      letter = known_letters[$urandom_range(0, 8)];
      cmd.push_back(CH_ESC);
      cmd.push_back(CH_INFO);
      cmd.push_back(letter);
      repeat (args_of_letter(letter)) cmd.push_back(rnd_byte());
    end
    fin = force_fin || ($urandom_range(1, fin_odds) == 1);
    foreach (cmd[i]) push_req(cmd[i], fin && (i == cmd.size() - 1), 1'b1);
    if (pick >= 40 && pick < 52) gen_tiff = (mode == MODE_TIFF);
    if (fin) begin
      gen_tiff = 1'b0;
      if (gen_skip && !force_fin) feed_preamble(200, 1'b1);
    end
  endtask

  // the one stop the run can afford: page end or some malformed input
  task automatic end_with_halt();
    logic [7:0] b;
    case ($urandom_range(0, 7))
      0: push_req(CH_PAGE_END, 1'b0, 1'b1);
      1: begin
        b = rnd_byte();
        while (b == CH_MODE || b == CH_RASTER || b == CH_EMPTY || b == CH_PAGE_END ||
               b == CH_ESC) b = rnd_byte();
        push_req(b, 1'b0, 1'b1);
      end
      2: begin
        b = rnd_byte();
        while (b == CH_INIT || b == CH_INFO) b = rnd_byte();
        push_req(CH_ESC, 1'b0, 1'b1);
        push_req(b, 1'b0, 1'b1);
      end
      3: begin
        b = rnd_byte();
        while (args_of_letter(b) >= 0) b = rnd_byte();
        push_req(CH_ESC, 1'b0, 1'b1);
        push_req(CH_INFO, 1'b0, 1'b1);
        push_req(b, 1'b0, 1'b1);
      end
      4: begin
        push_req(CH_RASTER, 1'b0, 1'b1);
        push_req(rnd_byte(), 1'b1, 1'b1);
      end
      5: begin
        // literal longer than what is left of the line
        push_req(CH_MODE, 1'b0, 1'b1);
        push_req(MODE_TIFF, 1'b0, 1'b1);
        push_req(CH_RASTER, 1'b0, 1'b1);
        push_req(8'h03, 1'b0, 1'b1);
        push_req(8'h00, 1'b0, 1'b1);
        push_req(8'($urandom_range(8'h02, 8'h7f)), 1'b0, 1'b1);
      end
      6: begin
        // repeat header as the last byte of the line
        push_req(CH_MODE, 1'b0, 1'b1);
        push_req(MODE_TIFF, 1'b0, 1'b1);
        push_req(CH_RASTER, 1'b0, 1'b1);
        push_req(8'h01, 1'b0, 1'b1);
        push_req(8'h00, 1'b0, 1'b1);
        push_req(8'($urandom_range(8'h81, 8'hff)), 1'b0, 1'b1);
      end
      default: begin
        push_req(CH_ESC, 1'b0, 1'b1);
        push_req(CH_INFO, 1'b0, 1'b1);
        push_req(CH_LET_U_UP, 1'b0, 1'b1);
        repeat (4) push_req(rnd_byte(), 1'b0, 1'b1);
        push_req(rnd_byte(), 1'b1, 1'b1);
      end
    endcase
  endtask

  task automatic drain();
    while (req_q.size() != 0 || in_valid || expected_q.size() != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_skip(input bit v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cfg_skip = v;
    gen_skip = v;
  endtask

  initial begin
    cfg_skip = 1'b1;
    halted = 1'b0;
    start_buffer();
    send_pct = 34;
    recv_pct = 75;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    feed_preamble(200, 1'b0);
    foreach (dir_rows[i]) begin
      req_q.push_back(dir_rows[i]);
      items_queued++;
    end
    // the last row closes the buffer
    feed_preamble(200, 1'b1);
    fin_odds = 50;
    while (items_queued < 600) gen_command(1'b0);
    gen_command(1'b1);

    // clear skipping part way into the preamble
    feed_preamble(37, 1'b0);
    drain();
    write_skip(1'b0);
    send_pct = 75;
    recv_pct = 34;
    fin_odds = 10;
    while (items_queued < 800) gen_command(1'b0);
    gen_command(1'b1);
    drain();

    write_skip(1'b1);
    send_pct = 0;
    recv_pct = 0;
    fin_odds = 40;
    feed_preamble(200, 1'b1);
    pressure_count++;
    while (items_queued < 1130) gen_command(1'b0);
    gen_command(1'b1);
    drain();

    write_skip(1'b0);
    fin_odds = 10;
    while (items_queued < 1280) gen_command(1'b0);
    end_with_halt();
    // halted from here on
    repeat (30) push_req(rnd_byte(), $urandom_range(0, 3) == 0, 1'b0);
    drain();
    repeat (10) @(posedge clk);

    if (expected_q.size() != 0)
      flag_mismatch($sformatf("%0d expected results never came", expected_q.size()));
    if (errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/lprcp_pkg.sv
rtl/core/label_printer_raster_command_parser.sv
test/tb.sv
